// File: rtl/core/mck_pkg.sv
// Shared types, constants and the Morse pattern table for the keyer.
`timescale 1ns / 1ps
package mck_pkg;

  localparam int unsigned PatW = 6;
  localparam int unsigned LenW = 3;
  localparam int unsigned CntW = 3;

  localparam logic [CntW-1:0] DotUnits   = CntW'(1);
  localparam logic [CntW-1:0] DashUnits  = CntW'(3);
  localparam logic [CntW-1:0] GapUnits   = CntW'(3);
  localparam logic [CntW-1:0] SpaceUnits = CntW'(7);

  // len of zero marks a word space; bits hold elements first-in-MSB, dash = 1
  typedef struct packed {
    logic [LenW-1:0] len;
    logic [PatW-1:0] bits;
  } morse_pat_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] code;
    logic       gap;
    logic       run_last;
    logic       msg_end;
  } mck_job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HELD,
    ST_LAST
  } mck_state_t;

  function automatic morse_pat_t morse_lookup(input logic [7:0] c);
    logic [7:0] u;
    morse_pat_t p;
    u = (c >= "a" && c <= "z") ? c - 8'h20 : c;
    case (u)
      "A": p = {3'd2, 6'b000001};
      "B": p = {3'd4, 6'b001000};
      "C": p = {3'd4, 6'b001010};
      "D": p = {3'd3, 6'b000100};
      "E": p = {3'd1, 6'b000000};
      "F": p = {3'd4, 6'b000010};
      "G": p = {3'd3, 6'b000110};
      "H": p = {3'd4, 6'b000000};
      "I": p = {3'd2, 6'b000000};
      "J": p = {3'd4, 6'b000111};
      "K": p = {3'd3, 6'b000101};
      "L": p = {3'd4, 6'b000100};
      "M": p = {3'd2, 6'b000011};
      "N": p = {3'd2, 6'b000010};
      "O": p = {3'd3, 6'b000111};
      "P": p = {3'd4, 6'b000110};
      "Q": p = {3'd4, 6'b001101};
      "R": p = {3'd3, 6'b000010};
      "S": p = {3'd3, 6'b000000};
      "T": p = {3'd1, 6'b000001};
      "U": p = {3'd3, 6'b000001};
      "V": p = {3'd4, 6'b000001};
      "W": p = {3'd3, 6'b000011};
      "X": p = {3'd4, 6'b001001};
      "Y": p = {3'd4, 6'b001011};
      "Z": p = {3'd4, 6'b001100};
      "0": p = {3'd5, 6'b011111};
      "1": p = {3'd5, 6'b001111};
      "2": p = {3'd5, 6'b000111};
      "3": p = {3'd5, 6'b000011};
      "4": p = {3'd5, 6'b000001};
      "5": p = {3'd5, 6'b000000};
      "6": p = {3'd5, 6'b010000};
      "7": p = {3'd5, 6'b011000};
      "8": p = {3'd5, 6'b011100};
      "9": p = {3'd5, 6'b011110};
      "/": p = {3'd5, 6'b010010};
      "=": p = {3'd5, 6'b010001};
      ".": p = {3'd6, 6'b010101};
      ",": p = {3'd6, 6'b110011};
      "?": p = {3'd6, 6'b001100};
      "+": p = {3'd5, 6'b001010};
      "@": p = {3'd6, 6'b011010};
      default: p = {3'd0, 6'b000000};
    endcase
    return p;
  endfunction

  function automatic logic morse_is_mark(input logic [7:0] c);
    morse_pat_t p;
    p = morse_lookup(c);
    return p.len != '0;
  endfunction

endpackage

// File: rtl/core/mck_if.sv
// Handshake interfaces for message characters and key units.
`timescale 1ns / 1ps
interface mck_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       final_char;

  modport source (output valid, output char_code, output final_char, input ready);
  modport sink (input valid, input char_code, input final_char, output ready);
endinterface

interface mck_out_if;
  logic valid;
  logic ready;
  logic tone_on;
  logic run_last;
  logic message_end;

  modport source (output valid, output tone_on, output run_last, output message_end,
                  input ready);
  modport sink (input valid, input tone_on, input run_last, input message_end,
                output ready);
endinterface

// File: rtl/core/mck_ser.sv
// Unit serializer: sends a character's elements as one key unit per cycle while unit_out is ready.
`timescale 1ns / 1ps
module mck_ser (
  input  logic            clk,
  input  logic            rst,
  input  mck_pkg::mck_job_t job,
  output logic            job_ready,
  mck_out_if.source       unit_out
);
  import mck_pkg::*;

  logic            busy;
  logic            tone;
  logic [CntW-1:0] run_cnt;
  logic [PatW-1:0] elems;
  logic [LenW-1:0] elem_cnt;
  logic            gap;
  logic            run_last;
  logic            msg_end;

  logic            out_valid;
  logic            out_tone;
  logic            out_last;
  logic            out_end;

  morse_pat_t      pat;
  logic [PatW-1:0] aligned;
  logic            advance;
  logic            run_done;
  logic            done;

  assign pat       = morse_lookup(job.code);
  assign aligned   = pat.bits << (LenW'(PatW) - pat.len);
  assign job_ready = !busy;
  assign advance   = !out_valid || unit_out.ready;
  assign run_done  = run_cnt == CntW'(1);
  assign done      = run_done && elem_cnt == '0 && (!tone || !gap);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (job.valid && !busy) begin
        busy     <= 1'b1;
        run_last <= job.run_last;
        msg_end  <= job.msg_end;
        if (unit_out.ready) begin
          out_valid <= 1'b0;
        end
        if (pat.len == '0) begin
          tone     <= 1'b0;
          run_cnt  <= SpaceUnits;
          elem_cnt <= '0;
          gap      <= 1'b0;
          elems    <= '0;
        end else begin
          tone     <= 1'b1;
          run_cnt  <= aligned[PatW-1] ? DashUnits : DotUnits;
          elems    <= aligned << 1;
          elem_cnt <= pat.len - LenW'(1);
          gap      <= job.gap;
        end
      end else if (busy && advance) begin
        out_valid <= 1'b1;
        out_tone  <= tone;
        out_last  <= done && run_last;
        out_end   <= done && msg_end;
        if (done) begin
          busy <= 1'b0;
        end else if (!run_done) begin
          run_cnt <= run_cnt - CntW'(1);
        end else if (tone && elem_cnt != '0) begin
          tone    <= 1'b0;
          run_cnt <= CntW'(1);
        end else if (tone) begin
          tone    <= 1'b0;
          run_cnt <= GapUnits;
          gap     <= 1'b0;
        end else begin
          tone     <= 1'b1;
          run_cnt  <= elems[PatW-1] ? DashUnits : DotUnits;
          elems    <= elems << 1;
          elem_cnt <= elem_cnt - LenW'(1);
        end
      end else if (unit_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign unit_out.valid       = out_valid;
  assign unit_out.tone_on     = out_tone;
  assign unit_out.run_last    = out_last;
  assign unit_out.message_end = out_end;

endmodule

// File: rtl/core/mck_ctrl.sv
// Hold control: keeps one character back and issues serializer jobs.
`timescale 1ns / 1ps
module mck_ctrl (
  input  logic              clk,
  input  logic              rst,
  mck_in_if.sink            char_in,
  input  logic              job_ready,
  output mck_pkg::mck_job_t job
);
  import mck_pkg::*;

  mck_state_t state;
  mck_state_t state_next;

  logic       held_valid;
  logic [7:0] held_char;
  logic [7:0] emit_char;
  logic [7:0] last_char;
  logic       last_fin;
  logic       gap;
  logic       accept;

  assign accept = char_in.valid && char_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      held_valid <= 1'b0;
      held_char  <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        held_valid <= !char_in.final_char;
        held_char  <= char_in.final_char ? 8'h00 : char_in.char_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      emit_char <= held_char;
      last_char <= char_in.char_code;
      last_fin  <= char_in.final_char;
      gap       <= morse_is_mark(held_char) && morse_is_mark(char_in.char_code);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (held_valid) begin
            state_next = ST_HELD;
          end else if (char_in.final_char) begin
            state_next = ST_LAST;
          end
        end
      end
      ST_HELD: begin
        if (job_ready) begin
          state_next = last_fin ? ST_LAST : ST_IDLE;
        end
      end
      ST_LAST: begin
        if (job_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    char_in.ready = 1'b0;
    job           = '0;
    unique case (state)
      ST_IDLE: begin
        char_in.ready = 1'b1;
      end
      ST_HELD: begin
        job.valid    = job_ready;
        job.code     = emit_char;
        job.gap      = gap;
        job.run_last = !last_fin;
      end
      ST_LAST: begin
        job.valid    = job_ready;
        job.code     = last_char;
        job.run_last = 1'b1;
        job.msg_end  = 1'b1;
      end
      default: begin
        char_in.ready = 1'b0;
      end
    endcase
  end

endmodule

// File: rtl/core/morse_code_keyer.sv
// Morse keyer top level: character input, key unit output.
// A released character passes the control state, the serializer load and the output register
// before its first unit is valid. Throughput: one unit per cycle while unit_out is ready, with
// a load step between characters; the serializer takes no new character until it has sent all
// units of the last one. A non-final first character is held.
// Synchronous reset clears the hold, the control state and the output register.
`timescale 1ns / 1ps
module morse_code_keyer (
  input  logic      clk,
  input  logic      rst,
  mck_in_if.sink    char_in,
  mck_out_if.source unit_out
);
  import mck_pkg::*;

  mck_job_t job;
  logic     job_ready;

  mck_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .char_in   (char_in),
    .job_ready (job_ready),
    .job       (job)
  );

  mck_ser u_ser (
    .clk       (clk),
    .rst       (rst),
    .job       (job),
    .job_ready (job_ready),
    .unit_out  (unit_out)
  );

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    unit_out.valid && unit_out.message_end |-> unit_out.run_last)
    else $error("message end without run end");

  a_load_takes: assert property (@(posedge clk) disable iff (rst)
    job.valid |=> !job_ready)
    else $error("serializer did not take job");

  a_busy_from_job: assert property (@(posedge clk) disable iff (rst)
    $fell(job_ready) |-> $past(job.valid))
    else $error("serializer started without a job");

endmodule

// File: bench/morse_code_keyer_tb.sv
// Testbench for the Morse keyer: words driven on char_in, predicted key units checked on unit_out.
`timescale 1ns / 1ps
module morse_code_keyer_tb;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned TailCycles = 50;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned WordCount  = 120;
  localparam int unsigned IdlePct    = 15;

  typedef struct {
    logic [7:0] code;
    logic       last;
    logic       drain;
  } char_word_t;

  typedef struct packed {
    logic tone;
    logic last;
    logic msg_end;
  } key_unit_t;

  string letter_code [26] = '{
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
    "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
    "..-", "...-", ".--", "-..-", "-.--", "--.."
  };
  string digit_code [10] = '{
    "-----", ".----", "..---", "...--", "....-",
    ".....", "-....", "--...", "---..", "----."
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  mck_in_if  char_in ();
  mck_out_if unit_out ();

  morse_code_keyer dut (
    .clk      (clk),
    .rst      (rst),
    .char_in  (char_in),
    .unit_out (unit_out)
  );

  char_word_t word_q [$];
  key_unit_t  unit_q [$];
  logic       held_ok;
  logic [7:0] held_code;
  int         words_sent;
  int         hold_left;
  logic       hold_armed;
  int         cycles;
  int         errors = 0;
  logic       calm;

  assign calm = words_sent >= 60 && words_sent < 90;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic string dots_dashes(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return letter_code[c - "A"];
    if (c >= "a" && c <= "z") return letter_code[c - "a"];
    if (c >= "0" && c <= "9") return digit_code[c - "0"];
    case (c)
      "/": return "-..-.";
      "=": return "-...-";
      ".": return ".-.-.-";
      ",": return "--..--";
      "?": return "..--..";
      "+": return ".-.-.";
      "@": return ".--.-.";
      default: return "";
    endcase
  endfunction

  function automatic logic is_mark(input logic [7:0] c);
    string p;
    p = dots_dashes(c);
    return p.len() != 0;
  endfunction

  task automatic push_units(input logic on, input int count);
    for (int i = 0; i < count; i++) unit_q.push_back(key_unit_t'{on, 1'b0, 1'b0});
  endtask

  task automatic key_char(input logic [7:0] c, input logic gap);
    string p;
    p = dots_dashes(c);
    if (p.len() == 0) begin
      push_units(1'b0, 7);
      return;
    end
    for (int i = 0; i < p.len(); i++) begin
      if (i > 0) push_units(1'b0, 1);
      push_units(1'b1, p[i] == "-" ? 3 : 1);
    end
    if (gap) push_units(1'b0, 3);
  endtask

  task automatic forecast_units(input char_word_t w);
    int        first;
    key_unit_t u;
    first = unit_q.size();
    if (held_ok) key_char(held_code, is_mark(held_code) && is_mark(w.code));
    if (w.last) begin
      key_char(w.code, 1'b0);
      held_ok = 1'b0;
      held_code = '0;
    end else begin
      held_ok = 1'b1;
      held_code = w.code;
    end
    if (unit_q.size() > first) begin
      u = unit_q.pop_back();
      u.last = 1'b1;
      if (w.last) u.msg_end = 1'b1;
      unit_q.push_back(u);
    end
  endtask

  task automatic report(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  task automatic add_word(input logic [7:0] code, input logic last, input logic drain = 1'b0);
    word_q.push_back('{code: code, last: last, drain: drain});
  endtask

  always @(posedge clk) begin : drive
    logic take;
    logic offer;
    if (rst) begin
      char_in.valid <= 1'b0;
      char_in.char_code <= '0;
      char_in.final_char <= 1'b0;
      words_sent <= 0;
      held_ok = 1'b0;
      held_code = '0;
    end else begin
      take = char_in.valid && char_in.ready;
      if (take) begin
        forecast_units(word_q.pop_front());
        words_sent <= words_sent + 1;
      end
      if (!char_in.valid || take) begin
        offer = word_q.size() != 0 && (calm || $urandom_range(99) >= IdlePct);
        if (offer && word_q[0].drain && unit_q.size() != 0) offer = 1'b0;
        char_in.valid <= offer;
        if (offer) begin
          char_in.char_code <= word_q[0].code;
          char_in.final_char <= word_q[0].last;
        end
      end
    end
  end

  always @(posedge clk) begin : sink_hold
    if (rst) begin
      hold_left <= 0;
      hold_armed <= 1'b1;
    end else if (hold_armed && words_sent >= 40) begin
      hold_left <= HoldCycles;
      hold_armed <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin : observe
    key_unit_t got;
    key_unit_t want;
    if (rst) begin
      unit_out.ready <= 1'b0;
    end else begin
      if (unit_out.valid && unit_out.ready) begin
        got = {unit_out.tone_on, unit_out.run_last, unit_out.message_end};
        if (unit_q.size() == 0) begin
          report($sformatf("unit %b with nothing expected", got));
        end else begin
          want = unit_q.pop_front();
          if (got !== want)
            report($sformatf("tone/run_last/message_end got %b want %b", got, want));
        end
      end
      unit_out.ready <= hold_left == 0 && (calm || $urandom_range(99) >= IdlePct);
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst) begin
      cycles <= 0;
    end else begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
        $display("[morse_code_keyer] ERROR");
        $finish;
      end
    end
  end

  initial begin
    string marks;
    string mapped;
    int    len;
    int    pick;
    logic  pause_late;
    logic [7:0] code;
    char_in.valid = 1'b0;
    char_in.char_code = '0;
    char_in.final_char = 1'b0;
    unit_out.ready = 1'b0;

    add_word("E", 1'b1);
    add_word("0", 1'b0);
    add_word("0", 1'b1);
    add_word("T", 1'b0);
    add_word(" ", 1'b0);
    add_word("z", 1'b1);
    add_word(8'h00, 1'b0);
    add_word(8'hFF, 1'b0);
    add_word(8'h80, 1'b1);
    marks = "/=.,?+@";
    for (int i = 0; i < marks.len(); i++) add_word(marks[i], i == marks.len() - 1);
    add_word("a", 1'b0);
    add_word("Z", 1'b0);
    add_word("9", 1'b0);
    add_word("#", 1'b1);

    mapped = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789/=.,?+@";
    pause_late = 1'b1;
    add_word("K", 1'b0, 1'b1);
    add_word("1", 1'b1);
    while (word_q.size() < WordCount) begin
      len = $urandom_range(1, 6);
      for (int k = 0; k < len; k++) begin
        pick = $urandom_range(99);
        if (pick < 70) code = mapped[$urandom_range(mapped.len() - 1)];
        else if (pick < 85) code = " ";
        else code = 8'($urandom_range(255));
        add_word(code, k == len - 1, k == 0 && pause_late && word_q.size() >= 95);
        if (k == 0 && word_q.size() > 95) pause_late = 1'b0;
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (word_q.size() != 0 || char_in.valid || unit_q.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (unit_q.size() != 0) report($sformatf("%0d units never arrived", unit_q.size()));
    if (errors == 0) begin
      $display("[morse_code_keyer] OK");
    end else begin
      $display("[morse_code_keyer] ERROR");
    end
    $finish;
  end
endmodule

// File: morse_code_keyer.f
rtl/core/mck_pkg.sv
rtl/core/mck_if.sv
rtl/core/mck_ser.sv
rtl/core/mck_ctrl.sv
rtl/core/morse_code_keyer.sv
bench/morse_code_keyer_tb.sv
